// ----- hw/rtl/srld_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the sprite run-length decoder
// no dependencies; compiled first

package srld_pkg;

    localparam int unsigned SPRITE_PIXEL_COUNT_DEF = 1024;
    localparam int unsigned BYTE_W                 = 8;
    localparam int unsigned COUNT_W                = 16;
    localparam int unsigned PIX_POS_W              = 10;
    localparam int unsigned APB_ADDR_W             = 3;
    localparam int unsigned APB_DATA_W             = 32;

    localparam logic [BYTE_W-1:0] OPAQUE_ALPHA = 8'hFF;

    // register index decoded from paddr[2]
    localparam logic REG_ALPHA_IN_STREAM = 1'b0;

    // stream parser phase
    typedef enum logic [2:0] {
        PH_SKIP_LO,
        PH_SKIP_HI,
        PH_COL_LO,
        PH_COL_HI,
        PH_RED,
        PH_GREEN,
        PH_BLUE,
        PH_ALPHA
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic                 pixel_write;
        logic                 sprite_end;
        logic [PIX_POS_W-1:0] pixel_position;
        logic [BYTE_W-1:0]    red;
        logic [BYTE_W-1:0]    green;
        logic [BYTE_W-1:0]    blue;
        logic [BYTE_W-1:0]    alpha;
    } t_out_item;

endpackage

// ----- hw/rtl/srld_if.sv -----
`timescale 1ns / 1ps
// valid/ready stream interfaces for the decoder's byte input and pixel output
// depends on srld_pkg for the payload structs

interface srld_in_if;
    logic                valid;
    logic                ready;
    srld_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srld_out_if;
    logic                valid;
    logic                ready;
    srld_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/sprite_run_length_decoder.sv -----
`timescale 1ns / 1ps
// sprite run-length decoder top level: byte parser, pixel writes, apb register
// depends on srld_pkg and the stream interfaces in srld_if.sv
//
// channel   direction  handshake          payload
// i_byte    in         valid/ready        data_byte, last_byte
// o_pix     out        valid/ready        pixel_write, sprite_end, pixel_position, r, g, b, a
// apb       in         psel/penable       alpha_in_stream at byte address 0
//
// one byte per cycle sustained while the result register is not stalled; a byte passes
// through the input register, then the parse logic into the result register
// one result at most per byte; bytes that complete no pixel and are not last give none
// synchronous active-low reset clears the parser, counters and the alpha mode
// a stalled result register holds both stages; input ready drops only when both are full and stalled

module sprite_run_length_decoder #(
    parameter int unsigned SPRITE_PIXEL_COUNT = srld_pkg::SPRITE_PIXEL_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    srld_in_if.sink                             i_byte,
    srld_out_if.source                          o_pix,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srld_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [srld_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [srld_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import srld_pkg::*;

    localparam int unsigned POS_W = $clog2(SPRITE_PIXEL_COUNT + 1);
    localparam int unsigned SUM_W = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;
    localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(SPRITE_PIXEL_COUNT);
    localparam logic [POS_W-1:0] CAP_POS = POS_W'(SPRITE_PIXEL_COUNT);

    // configuration register
    logic r_alpha_en;

    // input stage
    logic     r_in_valid;
    t_in_item r_in;

    // parser state
    t_phase              r_phase, n_phase;
    logic [BYTE_W-1:0]   r_low, n_low;
    logic [COUNT_W-1:0]  r_rem, n_rem;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [BYTE_W-1:0]   r_red, n_red;
    logic [BYTE_W-1:0]   r_green, n_green;
    logic [BYTE_W-1:0]   r_blue, n_blue;
    logic                r_finished, n_finished;

    // result stage
    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic              w_adv;
    logic              w_proc;
    logic              w_emit;
    logic [BYTE_W-1:0] w_alpha;
    logic [BYTE_W-1:0] w_blue;
    logic [SUM_W-1:0]  w_target;
    logic [POS_W:0]    w_pos_inc;

    // apb register access
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ALPHA_IN_STREAM) ?
                    APB_DATA_W'(r_alpha_en) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_en <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_ALPHA_IN_STREAM) begin
            r_alpha_en <= pwdata[0];
        end
    end

    // pipeline advance control
    assign w_adv        = !r_out_valid || o_pix.ready;
    assign w_proc       = r_in_valid && w_adv;
    assign i_byte.ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in <= i_byte.data;
        end
    end

    // skip target and pixel advance
    assign w_target  = SUM_W'(r_pos) + SUM_W'({r_in.data_byte, r_low});
    assign w_pos_inc = {1'b0, r_pos} + (POS_W+1)'(1);

    // parser next state and result
    always_comb begin
        n_phase    = r_phase;
        n_low      = r_low;
        n_rem      = r_rem;
        n_pos      = r_pos;
        n_red      = r_red;
        n_green    = r_green;
        n_blue     = r_blue;
        n_finished = r_finished;
        w_emit     = 1'b0;
        w_alpha    = '0;
        w_blue     = r_blue;
        n_out      = '0;

        if (w_proc && !r_finished) begin
            case (r_phase)
                PH_SKIP_LO: begin
                    n_low   = r_in.data_byte;
                    n_phase = PH_SKIP_HI;
                end
                PH_SKIP_HI: begin
                    if (w_target >= CAP_SUM) begin
                        n_pos      = CAP_POS;
                        n_finished = 1'b1;
                    end else begin
                        n_pos = POS_W'(w_target);
                    end
                    n_phase = PH_COL_LO;
                end
                PH_COL_LO: begin
                    n_low   = r_in.data_byte;
                    n_phase = PH_COL_HI;
                end
                PH_COL_HI: begin
                    n_rem   = {r_in.data_byte, r_low};
                    n_phase = ({r_in.data_byte, r_low} == '0) ? PH_SKIP_LO : PH_RED;
                end
                PH_RED: begin
                    n_red   = r_in.data_byte;
                    n_phase = PH_GREEN;
                end
                PH_GREEN: begin
                    n_green = r_in.data_byte;
                    n_phase = PH_BLUE;
                end
                PH_BLUE: begin
                    n_blue = r_in.data_byte;
                    w_blue = r_in.data_byte;
                    if (r_alpha_en) begin
                        n_phase = PH_ALPHA;
                    end else begin
                        w_emit  = 1'b1;
                        w_alpha = OPAQUE_ALPHA;
                    end
                end
                PH_ALPHA: begin
                    w_emit  = 1'b1;
                    w_alpha = r_in.data_byte;
                end
                default: begin
                    n_phase = PH_SKIP_LO;
                end
            endcase

            // completed pixel: write out and advance
            if (w_emit) begin
                n_out.pixel_write    = 1'b1;
                n_out.pixel_position = PIX_POS_W'(r_pos);
                n_out.red            = r_red;
                n_out.green          = r_green;
                n_out.blue           = w_blue;
                n_out.alpha          = w_alpha;
                n_pos                = POS_W'(w_pos_inc);
                n_rem                = r_rem - COUNT_W'(1);
                n_phase              = (r_rem == COUNT_W'(1)) ? PH_SKIP_LO : PH_RED;
                if (w_pos_inc >= (POS_W+1)'(SPRITE_PIXEL_COUNT)) begin
                    n_finished = 1'b1;
                end
            end
        end

        // end of sprite returns the parser to its start
        if (w_proc && r_in.last_byte) begin
            n_out.sprite_end = 1'b1;
            n_phase          = PH_SKIP_LO;
            n_low            = '0;
            n_rem            = '0;
            n_pos            = '0;
            n_finished       = 1'b0;
        end
    end

    // parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SKIP_LO;
            r_low      <= '0;
            r_rem      <= '0;
            r_pos      <= '0;
            r_finished <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_low      <= n_low;
            r_rem      <= n_rem;
            r_pos      <= n_pos;
            r_finished <= n_finished;
        end
    end

    // color bytes held until the pixel completes
    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_proc && (w_emit || r_in.last_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out;

    // position never passes the cap, and finished means it sits on it
    a_pos_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= CAP_POS)
        else $error("position beyond sprite pixel count");

    a_finished_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> r_pos == CAP_POS)
        else $error("finished while position below cap");

    // last byte restores the start state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in.last_byte) |=>
            (r_phase == PH_SKIP_LO && !r_finished && r_pos == '0))
        else $error("last byte did not clear parser state");

    // a result without a pixel only comes from the last byte
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.pixel_write) |-> r_out.sprite_end)
        else $error("empty result without end of sprite");

    // pixel phases always have pixels left to decode
    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RED || r_phase == PH_GREEN || r_phase == PH_BLUE ||
         r_phase == PH_ALPHA) |-> r_rem != '0)
        else $error("pixel phase with no colored pixels left");

endmodule

// ----- bench/sprite_run_length_decoder_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for sprite_run_length_decoder: byte stream in, pixel writes out
// depends on srld_pkg and the stream interfaces in srld_if.sv

module sprite_run_length_decoder_test;
    import srld_pkg::*;

    // tracks the parser state and holds the results still to come
    class pixel_scoreboard;
        int unsigned pixel_count;
        bit          alpha_mode;
        t_phase      ph;
        logic [7:0]  low_hold;
        logic [15:0] run_left;
        int unsigned pos;
        logic [23:0] color;
        bit          done;
        t_out_item   pending_writes[$];
        int          errors;

        function new(int unsigned pixels);
            pixel_count = pixels;
            alpha_mode  = 1'b0;
            errors      = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            ph       = PH_SKIP_LO;
            low_hold = '0;
            run_left = '0;
            pos      = 0;
            color    = '0;
            done     = 1'b0;
        endfunction

        function void set_alpha(logic [31:0] value);
            alpha_mode = value[0];
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction

        // advance the parser by one transferred byte
        function void note_byte(t_in_item it);
            t_out_item   res;
            bit          wr;
            int unsigned target;

            res    = '0;
            wr     = 1'b0;
            if (!done) begin
                case (ph)
                    PH_SKIP_LO: begin
                        low_hold = it.data_byte;
                        ph = PH_SKIP_HI;
                    end
                    PH_SKIP_HI: begin
                        target = pos + {it.data_byte, low_hold};
                        if (target >= pixel_count) begin
                            pos  = pixel_count;
                            done = 1'b1;
                        end else begin
                            pos = target;
                        end
                        ph = PH_COL_LO;
                    end
                    PH_COL_LO: begin
                        low_hold = it.data_byte;
                        ph = PH_COL_HI;
                    end
                    PH_COL_HI: begin
                        run_left = {it.data_byte, low_hold};
                        ph = (run_left == 0) ? PH_SKIP_LO : PH_RED;
                    end
                    PH_RED: begin
                        color = {16'h0, it.data_byte};
                        ph = PH_GREEN;
                    end
                    PH_GREEN: begin
                        color[15:8] = it.data_byte;
                        ph = PH_BLUE;
                    end
                    default: begin
                        if (ph == PH_BLUE)
                            color[23:16] = it.data_byte;
                        if (ph == PH_BLUE && alpha_mode) begin
                            ph = PH_ALPHA;
                        end else begin
                            // pixel complete
                            wr = 1'b1;
                            res.alpha = (ph == PH_BLUE) ? OPAQUE_ALPHA : it.data_byte;
                            res.pixel_position = pos[PIX_POS_W-1:0];
                            res.red   = color[7:0];
                            res.green = color[15:8];
                            res.blue  = color[23:16];
                            pos = pos + 1;
                            run_left = run_left - 1'b1;
                            if (pos >= pixel_count)
                                done = 1'b1;
                            ph = (run_left == 0) ? PH_SKIP_LO : PH_RED;
                        end
                    end
                endcase
            end

            if (it.last_byte)
                clear_stream();

            if (wr || it.last_byte) begin
                res.pixel_write = wr;
                res.sprite_end  = it.last_byte;
                pending_writes.push_back(res);
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(t_out_item got);
            t_out_item want;

            if (pending_writes.size() == 0) begin
                $error("result with nothing pending: %p", got);
                errors++;
                return;
            end
            want = pending_writes.pop_front();
            compare_field("pixel_write", want.pixel_write, got.pixel_write);
            compare_field("sprite_end", want.sprite_end, got.sprite_end);
            compare_field("pixel_position", want.pixel_position, got.pixel_position);
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("alpha", want.alpha, got.alpha);
        endfunction
    endclass

    localparam int unsigned PIXELS      = SPRITE_PIXEL_COUNT_DEF;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SETTLE      = 6;
    localparam int          PHASE_BYTES = 275;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [8:0]  LAST        = 9'h100;

    localparam logic [APB_ADDR_W-1:0] ADDR_ALPHA = {REG_ALPHA_IN_STREAM, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = 3'b100;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    srld_in_if  byte_if ();
    srld_out_if pix_if ();

    pixel_scoreboard sb;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_left     = 0;
    int sent_bytes    = 0;
    int cycle_count   = 0;

    sprite_run_length_decoder #(
        .SPRITE_PIXEL_COUNT (PIXELS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_pix   (pix_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock and reset
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // receiver: random stalls plus a long hold-off on request
    initial begin
        pix_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                pix_if.ready <= 1'b0;
                hold_left--;
            end else begin
                pix_if.ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    // check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready)
            sb.check_pixel(pix_if.data);
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // offer one byte, at times with a random gap before it, and wait for its transfer
    task automatic push_byte(input t_in_item it);
        if ($urandom_range(99) < in_idle_pct) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.data  <= it;
        do @(posedge i_clk); while (!(byte_if.valid && byte_if.ready));
        sb.note_byte(it);
        sent_bytes++;
    endtask

    // stop sending until every pending result has arrived and the pipe is empty
    task automatic drain_results();
        byte_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // apb write: setup then access
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ALPHA)
            sb.set_alpha(value);
    endtask

    function automatic t_in_item rand_byte();
        t_in_item it;
        it.data_byte = $urandom_range(0, 255);
        it.last_byte = 1'b0;
        return it;
    endfunction

    // one sprite: mostly well-formed groups, sometimes cut short or pure noise
    function automatic void build_sprite(input bit with_alpha, ref t_in_item seq[$]);
        int groups;
        int skip;
        int count;
        int px_bytes;
        int keep;
        t_in_item it;

        seq.delete();
        px_bytes = with_alpha ? 4 : 3;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 24)) seq.push_back(rand_byte());
        end else begin
            groups = $urandom_range(1, 4);
            repeat (groups) begin
                case ($urandom_range(9))
                    0:       skip = $urandom_range(0, 65535);
                    1, 2:    skip = $urandom_range(1015, 1030);
                    default: skip = $urandom_range(0, 24);
                endcase
                case ($urandom_range(9))
                    0:       count = 0;
                    1:       count = $urandom_range(0, 65535);
                    default: count = $urandom_range(1, 5);
                endcase
                // little-endian skip and colored counts
                it.last_byte = 1'b0;
                it.data_byte = skip[7:0];
                seq.push_back(it);
                it.data_byte = skip[15:8];
                seq.push_back(it);
                it.data_byte = count[7:0];
                seq.push_back(it);
                it.data_byte = count[15:8];
                seq.push_back(it);
                repeat (((count > 6) ? 6 : count) * px_bytes) seq.push_back(rand_byte());
            end
            // truncated stream
            if ($urandom_range(6) == 0) begin
                keep = $urandom_range(1, seq.size());
                while (seq.size() > keep) void'(seq.pop_back());
            end
        end
        seq[seq.size()-1].last_byte = 1'b1;
    endfunction

    // stimulus
    initial begin
        int in_idle_tab [4] = '{0, 49, 0, 35};
        int out_stall_tab [4] = '{0, 0, 49, 35};
        logic [31:0] alpha_tab [4] = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h1};
        logic [8:0] opening [$] = '{
            // zero colored count, run to the last pixel, ignored byte, end
            9'h000, 9'h000, 9'h000, 9'h000, 9'h0FE, 9'h003, 9'h003, 9'h000,
            9'h0FF, 9'h000, 9'h080, 9'h011, 9'h022, 9'h033, 9'h044, LAST | 9'h055,
            // skip past the end, ended on the high byte
            9'h0FF, LAST | 9'h0FF,
            // last byte completes a pixel
            9'h000, 9'h000, 9'h001, 9'h000, 9'h001, 9'h002, LAST | 9'h003,
            // cut short after one skip byte
            LAST | 9'h005
        };
        t_in_item seq[$];
        t_in_item it;

        byte_if.valid <= 1'b0;
        byte_if.data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        sb = new(PIXELS);

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // directed bytes with the alpha mode left at its reset value
        foreach (opening[k]) begin
            it.data_byte = opening[k][7:0];
            it.last_byte = opening[k][8];
            push_byte(it);
        end
        drain_results();

        for (int p = 0; p < 4; p++) begin
            in_idle_pct   = in_idle_tab[p];
            out_stall_pct = out_stall_tab[p];
            write_reg(ADDR_ALPHA, alpha_tab[p]);
            if (p == 2)
                write_reg(ADDR_SPARE, 32'hFFFF_FFFF);
            // long receiver hold-off while bytes keep coming
            if (p == 0)
                hold_left = HOLD_CYCLES;
            sent_bytes = 0;
            while (sent_bytes < PHASE_BYTES) begin
                build_sprite(sb.alpha_mode, seq);
                foreach (seq[k]) push_byte(seq[k]);
            end
            drain_results();
        end

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
